### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Shared geometry, character codes, command codes and item types of the text
// console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int LAST_ROW_BASE = CELLS - COLUMNS;

	localparam int COL_W    = $clog2(COLUMNS);
	localparam int COLX_W   = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int ROWX_W   = $clog2(ROWS + 1);
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int OFFSET_W = 11;

	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] ATTR_RESET = 8'h0F;

	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_PUT_AT = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	typedef enum logic [2:0] {
		OP_PRINT,
		OP_TAB,
		OP_CR,
		OP_LF,
		OP_BS,
		OP_NUL,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [6:0] target_col;
		logic [4:0] target_row;
	} in_item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] cursor_pos;
		logic [7:0]          read_char;
		logic [7:0]          read_attr;
		logic                scrolled;
	} out_item_t;

	typedef struct packed {
		op_t              op;
		logic             set_pos;
		logic [7:0]       ch;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} back_cmd_t;

endpackage

### design/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer
// Console of 80 by 25 character cells with cursor, control codes, scrolling,
// cell reads and screen clear, fed through a command queue.
// ----------------------------------------------------------------------------
// Each item passes from the command queue through the back end's sequencer
// (idle, execute, then finish; a read adds a read state), which carries out one
// operation at a time while the queue takes new items until it is full. A scroll
// adds a copy and blank sweep over the cell memory's single write port; a clear adds a blank sweep.
// Reset clears the cursor to home, the attribute to 0x0F, the command queue and
// the result register; the cell memory is not cleared and is undefined until written.
module text_console_char_writer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tcw_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output tcw_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import tcw_pkg::*;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	back_cmd_t q_wr_data;
	back_cmd_t q_rd_data;

	assign cfg_ready = 1'b1;

	tcw_front u_front (
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wr_data)
	);

	tcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	tcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.q_empty  (q_empty),
		.q_data   (q_rd_data),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

### design/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console front end
// Accepts input items, clamps the target cell and decodes each item into one
// back-end operation for the command queue.
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic               push,
	output logic               full,
	input  tcw_pkg::in_item_t  in_item,
	input  logic               q_full,
	output logic               q_push,
	output tcw_pkg::back_cmd_t q_data
);
	import tcw_pkg::*;

	op_t char_op;

	always_comb begin
		case (in_item.char_code)
			CH_TAB:  char_op = OP_TAB;
			CH_CR:   char_op = OP_CR;
			CH_LF:   char_op = OP_LF;
			CH_BS:   char_op = OP_BS;
			CH_NUL:  char_op = OP_NUL;
			default: char_op = OP_PRINT;
		endcase
	end

	always_comb begin
		q_data.ch      = in_item.char_code;
		q_data.set_pos = (in_item.cmd == CMD_PUT_AT);
		if (int'(in_item.target_col) >= COLUMNS) begin
			q_data.col = COL_W'(COLUMNS - 1);
		end else begin
			q_data.col = in_item.target_col[COL_W-1:0];
		end
		if (int'(in_item.target_row) >= ROWS) begin
			q_data.row = ROW_W'(ROWS - 1);
		end else begin
			q_data.row = in_item.target_row[ROW_W-1:0];
		end
		case (in_item.cmd)
			CMD_PUT, CMD_PUT_AT: q_data.op = char_op;
			CMD_READ:            q_data.op = OP_READ;
			CMD_CLEAR:           q_data.op = OP_CLEAR;
			default:             q_data.op = OP_NUL;
		endcase
	end

	assign full   = q_full;
	assign q_push = push & ~q_full;

endmodule

### design/tcw_queue.sv
// ----------------------------------------------------------------------------
// Text console command queue
// Short first-in first-out queue of decoded operations between the front end
// and the back end.
// ----------------------------------------------------------------------------
module tcw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  tcw_pkg::back_cmd_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output tcw_pkg::back_cmd_t rd_data,
	output logic               empty
);
	import tcw_pkg::*;

	back_cmd_t          slots_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console back end
// Holds the cursor, the attribute register and the cell memory, and carries
// out one operation at a time, including scroll and clear sweeps.
// ----------------------------------------------------------------------------
module tcw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data,
	input  logic                q_empty,
	input  tcw_pkg::back_cmd_t  q_data,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output tcw_pkg::out_item_t  out_item
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCROLL,
		S_FILL,
		S_FINISH
	} state_t;

	state_t            state_q;
	back_cmd_t         cmd_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [7:0]        attr_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              scrolled_q;
	logic [7:0]        rchar_q;
	logic [7:0]        rattr_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              out_load;

	logic [15:0]       mem [CELLS];
	logic [15:0]       rd_data_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [15:0]       mem_wd;
	logic [ADDR_W-1:0] mem_ra;

	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] tgt_addr;
	logic [15:0]       blank;
	logic [COLX_W-1:0] col_x;
	logic [ROWX_W-1:0] row_x;
	logic              do_scroll;
	logic              ex_we;
	logic [ADDR_W-1:0] ex_wa;
	logic [15:0]       ex_wd;

	assign cur_addr = ADDR_W'(int'(row_q) * COLUMNS) + ADDR_W'(col_q);
	assign tgt_addr = ADDR_W'(int'(cmd_q.row) * COLUMNS) + ADDR_W'(cmd_q.col);
	assign blank    = {attr_q, CH_SPACE};

	always_comb begin
		col_x = COLX_W'(col_q);
		row_x = ROWX_W'(row_q);
		ex_we = 1'b0;
		ex_wa = cur_addr;
		ex_wd = blank;
		case (cmd_q.op)
			OP_PRINT: begin
				col_x = COLX_W'(col_q) + 1'b1;
				ex_we = 1'b1;
				ex_wd = {attr_q, cmd_q.ch};
			end
			OP_TAB: begin
				col_x = COLX_W'(col_q) + COLX_W'(TAB_STOP) - COLX_W'(col_q % TAB_STOP);
			end
			OP_CR: begin
				col_x = '0;
			end
			OP_LF: begin
				row_x = ROWX_W'(row_q) + 1'b1;
				col_x = '0;
			end
			OP_BS: begin
				if (row_q != '0 || col_q != '0) begin
					ex_we = 1'b1;
					ex_wa = cur_addr - 1'b1;
					if (col_q == '0) begin
						row_x = ROWX_W'(row_q) - 1'b1;
						col_x = COLX_W'(COLUMNS - 1);
					end else begin
						col_x = COLX_W'(col_q) - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (col_x >= COLX_W'(COLUMNS)) begin
			row_x = row_x + 1'b1;
			col_x = '0;
		end
		do_scroll = (row_x >= ROWX_W'(ROWS));
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q;
		mem_wd = blank;
		mem_ra = tgt_addr;
		case (state_q)
			S_EXEC: begin
				mem_we = ex_we;
				mem_wa = ex_wa;
				mem_wd = ex_wd;
			end
			S_SCROLL: begin
				mem_we = (ptr_q != '0);
				mem_wa = ptr_q - 1'b1;
				mem_wd = rd_data_q;
				mem_ra = (ptr_q == ADDR_W'(LAST_ROW_BASE)) ? '0 : ptr_q + ADDR_W'(COLUMNS);
			end
			S_FILL: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	assign q_pop    = (state_q == S_IDLE) & ~q_empty;
	assign empty    = ~out_valid_q;
	assign out_item = out_q;
	assign out_load = (state_q == S_FINISH) & (~out_valid_q | pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			attr_q      <= ATTR_RESET;
			ptr_q       <= '0;
			scrolled_q  <= 1'b0;
			rchar_q     <= '0;
			rattr_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_data;
						if (q_data.set_pos) begin
							col_q <= q_data.col;
							row_q <= q_data.row;
						end
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					scrolled_q <= do_scroll;
					rchar_q    <= '0;
					rattr_q    <= '0;
					ptr_q      <= '0;
					case (cmd_q.op)
						OP_READ: begin
							state_q <= S_READ;
						end
						OP_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							state_q <= S_FILL;
						end
						default: begin
							if (do_scroll) begin
								col_q   <= '0;
								row_q   <= ROW_W'(ROWS - 1);
								state_q <= S_SCROLL;
							end else begin
								col_q   <= col_x[COL_W-1:0];
								row_q   <= row_x[ROW_W-1:0];
								state_q <= S_FINISH;
							end
						end
					endcase
				end
				S_READ: begin
					rchar_q <= rd_data_q[7:0];
					rattr_q <= rd_data_q[15:8];
					state_q <= S_FINISH;
				end
				S_SCROLL: begin
					if (ptr_q == ADDR_W'(LAST_ROW_BASE)) begin
						state_q <= S_FILL;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_FILL: begin
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= S_FINISH;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						out_q.cursor_pos <= OFFSET_W'(int'(row_q) * COLUMNS + int'(col_q));
						out_q.read_char  <= rchar_q;
						out_q.read_attr  <= rattr_q;
						out_q.scrolled   <= scrolled_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console checker
// Port-level assertions on the result side of the text console writer.
// ----------------------------------------------------------------------------
module tcw_port_props (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input tcw_pkg::out_item_t out_item
);
	import tcw_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("Waiting item changed or vanished before it was taken.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (int'(out_item.cursor_pos) < CELLS))
		else $error("Cursor offset lies outside the screen.");

	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.scrolled) |->
		(int'(out_item.cursor_pos) == (ROWS - 1) * COLUMNS))
		else $error("A scroll did not leave the cursor at the start of the last row.");

endmodule

bind text_console_char_writer tcw_port_props u_tcw_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);
